@@ rtl/core/carg_pkg.sv @@
package carg_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int CMP_BITS     = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int MAX_EVENTS   = 3;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_CMD  = 2'd1;
    localparam logic [1:0] FUNC_RX   = 2'd2;

    localparam logic [7:0] MARK_FIRST  = 8'hFC;
    localparam logic [7:0] MARK_SECOND = 8'hBB;

    localparam logic [2:0] CFG_OWN_ID       = 3'd0;
    localparam logic [2:0] CFG_PARTNER_ID   = 3'd1;
    localparam logic [2:0] CFG_ACK_TIMEOUT  = 3'd2;
    localparam logic [2:0] CFG_MAX_RETRIES  = 3'd3;
    localparam logic [2:0] CFG_HB_TIMEOUT   = 3'd4;
    localparam logic [2:0] CFG_UPDATE_CODE  = 3'd5;
    localparam logic [2:0] CFG_RESTART_CODE = 3'd6;

    typedef enum logic [3:0] {
        EV_SENT_WAITING = 4'd0,
        EV_UPDATE_SENT  = 4'd1,
        EV_RESTART_SENT = 4'd2,
        EV_BUSY         = 4'd3,
        EV_RESEND       = 4'd4,
        EV_FAILED       = 4'd5,
        EV_OFFLINE      = 4'd6,
        EV_UPDATE_DONE  = 4'd7,
        EV_ONLINE       = 4'd8,
        EV_SUCCESS      = 4'd9
    } event_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  cmd_device;
        logic [7:0]  cmd_action;
        logic [10:0] rx_frame_id;
        logic [7:0]  rx_first_byte;
        logic [7:0]  rx_second_byte;
    } in_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic        frame_valid;
        logic [10:0] frame_id;
        logic [7:0]  frame_first_byte;
        logic [7:0]  frame_second_byte;
        logic        last;
    } out_t;

    // events of one item; only the first one can carry a frame
    typedef struct packed {
        logic [1:0]             n;
        event_t [MAX_EVENTS-1:0] ev;
        logic [10:0]            frame_id;
        logic [7:0]             first_byte;
        logic [7:0]             second_byte;
    } bundle_t;

    function automatic logic is_tx_event(input event_t e);
        return (e == EV_SENT_WAITING) || (e == EV_UPDATE_SENT) ||
               (e == EV_RESTART_SENT) || (e == EV_RESEND);
    endfunction

endpackage

@@ rtl/core/carg_front.sv @@
module carg_front
    import carg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_t         item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_full,
    output logic        push,
    output bundle_t     push_data
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [10:0] own_id_reg;
    logic [10:0] partner_id_reg;
    logic [15:0] ack_timeout_reg;
    logic [2:0]  max_retries_reg;
    logic [15:0] hb_timeout_reg;
    logic [7:0]  update_code_reg;
    logic [7:0]  restart_code_reg;

    logic                    awaiting_reg, awaiting_next;
    logic [2:0]              resend_cnt_reg, resend_cnt_next;
    logic [7:0]              held_dev_reg, held_dev_next;
    logic [7:0]              held_act_reg, held_act_next;
    logic [COUNTER_BITS-1:0] since_send_reg, since_send_next;
    logic [COUNTER_BITS-1:0] since_heard_reg, since_heard_next;
    logic                    up_reg, up_next;

    logic    accept;
    logic [1:0] cnt;
    bundle_t b;

    function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign accept     = item_valid && !q_full;
    assign item_stall = q_full;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        awaiting_next    = awaiting_reg;
        resend_cnt_next  = resend_cnt_reg;
        held_dev_next    = held_dev_reg;
        held_act_next    = held_act_reg;
        since_send_next  = since_send_reg;
        since_heard_next = since_heard_reg;
        up_next          = up_reg;
        b   = '0;
        cnt = 2'd0;
        case (item.func)
            FUNC_TICK:
            begin
                since_send_next  = bump(since_send_reg);
                since_heard_next = bump(since_heard_reg);
                if (awaiting_reg &&
                    CMP_BITS'(since_send_next) > CMP_BITS'(ack_timeout_reg))
                begin
                    if (resend_cnt_reg < max_retries_reg)
                    begin
                        b.ev[0]         = EV_RESEND;
                        b.frame_id      = own_id_reg;
                        b.first_byte    = held_dev_reg;
                        b.second_byte   = held_act_reg;
                        resend_cnt_next = resend_cnt_reg + 3'd1;
                        since_send_next = '0;
                    end
                    else
                    begin
                        b.ev[0]       = EV_FAILED;
                        awaiting_next = 1'b0;
                    end
                    cnt = 2'd1;
                end
                if (up_reg && CMP_BITS'(since_heard_next) > CMP_BITS'(hb_timeout_reg))
                begin
                    up_next  = 1'b0;
                    b.ev[cnt] = EV_OFFLINE;
                    cnt      = cnt + 2'd1;
                end
            end
            FUNC_CMD:
            begin
                cnt = 2'd1;
                if (awaiting_reg)
                begin
                    b.ev[0] = EV_BUSY;
                end
                else
                begin
                    b.frame_id    = own_id_reg;
                    b.first_byte  = item.cmd_device;
                    b.second_byte = item.cmd_action;
                    if (item.cmd_device == update_code_reg)
                    begin
                        b.ev[0] = EV_UPDATE_SENT;
                    end
                    else if (item.cmd_device == restart_code_reg)
                    begin
                        b.ev[0] = EV_RESTART_SENT;
                    end
                    else
                    begin
                        b.ev[0]         = EV_SENT_WAITING;
                        held_dev_next   = item.cmd_device;
                        held_act_next   = item.cmd_action;
                        awaiting_next   = 1'b1;
                        resend_cnt_next = 3'd0;
                        since_send_next = '0;
                    end
                end
            end
            FUNC_RX:
            begin
                if (item.rx_frame_id == partner_id_reg)
                begin
                    since_heard_next = '0;
                    if (item.rx_first_byte == MARK_FIRST && item.rx_second_byte == MARK_SECOND)
                    begin
                        b.ev[cnt] = EV_UPDATE_DONE;
                        cnt       = cnt + 2'd1;
                    end
                    if (!up_reg)
                    begin
                        up_next   = 1'b1;
                        b.ev[cnt] = EV_ONLINE;
                        cnt       = cnt + 2'd1;
                    end
                    if (awaiting_reg && item.rx_first_byte == held_dev_reg)
                    begin
                        awaiting_next   = 1'b0;
                        resend_cnt_next = 3'd0;
                        b.ev[cnt]       = EV_SUCCESS;
                        cnt             = cnt + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        b.n = cnt;
    end

    assign push      = accept && (cnt != 2'd0);
    assign push_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg       <= 11'h110;
            partner_id_reg   <= 11'h220;
            ack_timeout_reg  <= 16'd200;
            max_retries_reg  <= 3'd3;
            hb_timeout_reg   <= 16'd15000;
            update_code_reg  <= 8'h11;
            restart_code_reg <= 8'h33;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OWN_ID:       own_id_reg       <= cfg_data[10:0];
                CFG_PARTNER_ID:   partner_id_reg   <= cfg_data[10:0];
                CFG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_data;
                CFG_MAX_RETRIES:  max_retries_reg  <= cfg_data[2:0];
                CFG_HB_TIMEOUT:   hb_timeout_reg   <= cfg_data;
                CFG_UPDATE_CODE:  update_code_reg  <= cfg_data[7:0];
                CFG_RESTART_CODE: restart_code_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg    <= 1'b0;
            resend_cnt_reg  <= 3'd0;
            held_dev_reg    <= 8'd0;
            held_act_reg    <= 8'd0;
            since_send_reg  <= '0;
            since_heard_reg <= '0;
            up_reg          <= 1'b1;
        end
        else if (accept)
        begin
            awaiting_reg    <= awaiting_next;
            resend_cnt_reg  <= resend_cnt_next;
            held_dev_reg    <= held_dev_next;
            held_act_reg    <= held_act_next;
            since_send_reg  <= since_send_next;
            since_heard_reg <= since_heard_next;
            up_reg          <= up_next;
        end
    end

endmodule

@@ rtl/core/carg_queue.sv @@
module carg_queue
    import carg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    bundle_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/carg_back.sv @@
module carg_back
    import carg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t head,
    input  logic    empty,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_stall,
    output out_t    res
);

    logic [1:0] idx_reg;
    logic       res_valid_reg;
    out_t       res_reg, res_next;
    logic       load, is_last, tx;
    event_t     cur;

    assign load    = !empty && (!res_valid_reg || !res_stall);
    assign cur     = head.ev[idx_reg];
    assign tx      = is_tx_event(cur);
    assign is_last = (idx_reg == 2'(head.n - 2'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        res_next.event_res         = cur;
        res_next.frame_valid       = tx;
        res_next.frame_id          = tx ? head.frame_id : 11'd0;
        res_next.frame_first_byte  = tx ? head.first_byte : 8'd0;
        res_next.frame_second_byte = tx ? head.second_byte : 8'd0;
        res_next.last              = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                res_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/command_ack_retry_controller.sv @@
// Stop-and-wait command sender with partner heartbeat. Each input word is a
// tick, a new command or a received frame; the front end updates all state
// in the cycle it takes the word and queues that word's events (zero to
// three) in a four-entry queue. The back end hands out one result word per
// cycle through an output register while res_stall is low, so a new input
// word is taken every cycle while the queue has room and a word's results
// follow one per cycle behind it unless the output stalls; sustained rate
// is set by the back end at one result per cycle. Configuration writes
// are always taken (cfg_ready is high) and act from the next cycle.
module command_ack_retry_controller
    import carg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_t         item,
    output logic        res_valid,
    input  logic        res_stall,
    output out_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    push, pop, q_full, q_empty;
    bundle_t push_data, head;

    carg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    carg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    carg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

@@ rtl/core/carg_checker.sv @@
module carg_checker
    import carg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input out_t        res
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed under stall");

    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.event_res <= EV_SUCCESS)
        else $error("event code out of range");

    a_tx_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.frame_valid == (res.event_res == EV_SENT_WAITING ||
                                          res.event_res == EV_UPDATE_SENT ||
                                          res.event_res == EV_RESTART_SENT ||
                                          res.event_res == EV_RESEND))
        else $error("frame_valid does not match event");

    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.frame_valid |->
            res.frame_id == 11'd0 && res.frame_first_byte == 8'd0 &&
            res.frame_second_byte == 8'd0)
        else $error("frame fields set without a frame");

endmodule

bind command_ack_retry_controller carg_checker u_carg_checker (.*);
